[hw/rtl/msps_pkg.sv]
package msps_pkg;

  localparam int NUM_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 64;
  localparam int IDX_W           = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W           = 7;
  localparam int POS_W           = 32;
  localparam int PAT_W           = 2;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERNS_IN_USE = 3'd0,
    REG_REQUIRE_UNIQUE  = 3'd1,
    REG_LENGTH_ZERO     = 3'd2,
    REG_LENGTH_ONE      = 3'd3,
    REG_LENGTH_TWO      = 3'd4,
    REG_LENGTH_THREE    = 3'd5
  } cfg_reg_e;

  localparam logic CMD_PATTERN_WRITE = 1'b0;
  localparam logic CMD_SECTION_BYTE  = 1'b1;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;

  typedef struct packed {
    logic             command;
    logic [1:0]       pattern_select;
    logic [IDX_W-1:0] pattern_position;
    logic [7:0]       byte_value;
    logic             is_wildcard;
    logic             section_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       search_status;
    logic [PAT_W-1:0] matched_pattern;
    logic [POS_W-1:0] match_offset;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                         patterns_in_use;
    logic                               require_unique;
    logic [NUM_PATTERNS-1:0][LEN_W-1:0] pattern_length;
  } cfg_t;

  // One section byte after the shift-and step: which patterns completed a
  // match, and how far back each match starts.
  typedef struct packed {
    logic [NUM_PATTERNS-1:0]            hit;
    logic [NUM_PATTERNS-1:0][LEN_W-1:0] span;
    logic [POS_W-1:0]                   position;
    logic                               last;
  } scan_entry_t;

  typedef struct packed {
    logic             hit;
    logic             spread;
    logic [PAT_W-1:0] pat;
    logic [POS_W-1:0] start;
  } cand_t;

  // Combine two match candidates; lo holds the lower pattern indexes.
  function automatic cand_t merge_cand(cand_t lo, cand_t hi);
    cand_t r;
    r = lo;
    if (lo.hit && hi.hit) begin
      r.spread = lo.spread | hi.spread | (lo.start != hi.start);
      if (hi.start < lo.start) begin
        r.pat   = hi.pat;
        r.start = hi.start;
      end
    end else if (hi.hit) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

[hw/rtl/masked_multi_pattern_search_core.sv]
// Wildcard byte signature scanner.
// Input channel (in_valid / in_stall / in_item): an item either writes one
// pattern byte with its wildcard bit, or presents one section byte; the byte
// flagged section_end closes the section. Output channel (out_valid /
// out_stall / out_item) carries one result per section: status, pattern
// index and earliest match offset.
// Configuration is written through cfg_write_enable / cfg_index / cfg_data,
// one register per cycle, while no section is in flight.
// Throughput: one item per cycle while in_stall is low. All four shift-and
// vectors advance in the front in the cycle a section byte is taken; a
// four-entry queue feeds a three-stage back end (start offsets with pair
// reduction, final candidate merge, summary merge).
// A stalled result holds the back end, the queue then fills, and in_stall
// rises once all four queue entries are in use; pattern writes are held too.
// Reset clears the configuration to one pattern of length one, the match
// vectors, the section position and any pending result. Pattern bytes are not
// cleared and must be written before they are used.
module masked_multi_pattern_search_core import msps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        queue_full;
  logic        push;
  scan_entry_t push_entry;
  logic        pop;
  logic        head_valid;
  scan_entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.patterns_in_use <= 3'd1;
      cfg.require_unique  <= 1'b0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        cfg.pattern_length[p] <= LEN_W'(1);
      end
    end else if (cfg_write_enable) begin
      case (cfg_reg_e'(cfg_index))
        REG_PATTERNS_IN_USE: cfg.patterns_in_use   <= cfg_data[2:0];
        REG_REQUIRE_UNIQUE:  cfg.require_unique    <= cfg_data[0];
        REG_LENGTH_ZERO:     cfg.pattern_length[0] <= cfg_data[LEN_W-1:0];
        REG_LENGTH_ONE:      cfg.pattern_length[1] <= cfg_data[LEN_W-1:0];
        REG_LENGTH_TWO:      cfg.pattern_length[2] <= cfg_data[LEN_W-1:0];
        REG_LENGTH_THREE:    cfg.pattern_length[3] <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  msps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  msps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .require_unique (cfg.require_unique),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule

[hw/rtl/msps_front.sv]
module msps_front import msps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  input  cfg_t        cfg,
  input  logic        queue_full,
  output logic        push,
  output scan_entry_t push_entry
);

  logic [7:0]                 pattern_byte [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic                       wild_bit     [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [MAX_PATTERN_LEN-1:0] vec          [NUM_PATTERNS];
  logic [MAX_PATTERN_LEN-1:0] vec_next     [NUM_PATTERNS];
  logic [MAX_PATTERN_LEN-1:0] byte_mask    [NUM_PATTERNS];
  logic [MAX_PATTERN_LEN-1:0] step_vec     [NUM_PATTERNS];
  logic [LEN_W-1:0]           len_eff      [NUM_PATTERNS];
  logic [LEN_W-1:0]           tail         [NUM_PATTERNS];
  logic [POS_W-1:0]           position;
  logic [2:0]                 active_cnt;
  logic                       accept;
  logic                       is_byte;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign is_byte  = (in_item.command == CMD_SECTION_BYTE);

  always_comb begin
    active_cnt = (cfg.patterns_in_use > 3'(NUM_PATTERNS)) ? 3'(NUM_PATTERNS)
                                                          : cfg.patterns_in_use;
    push_entry.position = position;
    push_entry.last     = in_item.section_end;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      len_eff[p] = (cfg.pattern_length[p] > LEN_W'(MAX_PATTERN_LEN)) ?
                   LEN_W'(MAX_PATTERN_LEN) : cfg.pattern_length[p];
      for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
        byte_mask[p][j] = (LEN_W'(j) < len_eff[p]) &&
                          (wild_bit[p][j] || pattern_byte[p][j] == in_item.byte_value);
      end
      step_vec[p] = ((vec[p] << 1) | {{(MAX_PATTERN_LEN-1){1'b0}}, 1'b1}) & byte_mask[p];
      tail[p]     = len_eff[p] - LEN_W'(1);
      if (3'(p) >= active_cnt) begin
        vec_next[p]        = '0;
        push_entry.hit[p]  = 1'b0;
        push_entry.span[p] = LEN_W'(1);
      end else if (len_eff[p] == '0) begin
        // empty pattern matches at the current byte itself
        vec_next[p]        = '0;
        push_entry.hit[p]  = 1'b1;
        push_entry.span[p] = LEN_W'(1);
      end else begin
        vec_next[p]        = step_vec[p];
        push_entry.hit[p]  = step_vec[p][tail[p][IDX_W-1:0]];
        push_entry.span[p] = len_eff[p];
      end
    end
  end

  assign push = accept && is_byte;

  always_ff @(posedge clk) begin
    if (accept && !is_byte) begin
      if ((32'(in_item.pattern_select) < NUM_PATTERNS) &&
          (32'(in_item.pattern_position) < MAX_PATTERN_LEN)) begin
        pattern_byte[in_item.pattern_select][in_item.pattern_position] <= in_item.byte_value;
        wild_bit[in_item.pattern_select][in_item.pattern_position]     <= in_item.is_wildcard;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        vec[p] <= '0;
      end
    end else if (push) begin
      // drop section state after the final byte
      position <= in_item.section_end ? '0 : position + POS_W'(1);
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        vec[p] <= in_item.section_end ? '0 : vec_next[p];
      end
    end
  end

endmodule

[hw/rtl/msps_queue.sv]
module msps_queue import msps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  scan_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output scan_entry_t head
);

  scan_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/msps_back.sv]
module msps_back import msps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  scan_entry_t head,
  output logic        pop,
  input  logic        require_unique,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  cand_t            cand [NUM_PATTERNS];
  cand_t            pair [2];
  cand_t            s1_pair [2];
  logic             s1_valid;
  logic             s1_last;
  cand_t            s2_cand;
  logic             s2_valid;
  logic             s2_last;
  logic             adv;

  logic             match_seen;
  logic             second_start_seen;
  logic [POS_W-1:0] best_start;
  logic [PAT_W-1:0] best_pattern;
  logic             match_seen_next;
  logic             second_start_seen_next;
  logic [POS_W-1:0] best_start_next;
  logic [PAT_W-1:0] best_pattern_next;
  out_item_t        result;

  // stage 1: match starts and pairwise reduction
  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      cand[p].hit    = head.hit[p];
      cand[p].spread = 1'b0;
      cand[p].pat    = PAT_W'(p);
      cand[p].start  = head.position + POS_W'(1) - POS_W'(head.span[p]);
    end
    pair[0] = merge_cand(cand[0], cand[1]);
    pair[1] = merge_cand(cand[2], cand[3]);
  end

  // stage 3: fold this byte's best candidate into the section summary
  always_comb begin
    match_seen_next        = match_seen;
    second_start_seen_next = second_start_seen;
    best_start_next        = best_start;
    best_pattern_next      = best_pattern;
    if (s2_valid && s2_cand.hit) begin
      if (!match_seen) begin
        match_seen_next        = 1'b1;
        second_start_seen_next = s2_cand.spread;
        best_start_next        = s2_cand.start;
        best_pattern_next      = s2_cand.pat;
      end else begin
        second_start_seen_next = second_start_seen | s2_cand.spread |
                                 (s2_cand.start != best_start);
        if ((s2_cand.start < best_start) ||
            (s2_cand.start == best_start && s2_cand.pat < best_pattern)) begin
          best_start_next   = s2_cand.start;
          best_pattern_next = s2_cand.pat;
        end
      end
    end
    if (!match_seen_next) begin
      result.search_status   = STATUS_NOT_FOUND;
      result.matched_pattern = '0;
      result.match_offset    = '0;
    end else if (require_unique && second_start_seen_next) begin
      result.search_status   = STATUS_DUPLICATE;
      result.matched_pattern = '0;
      result.match_offset    = '0;
    end else begin
      result.search_status   = STATUS_FOUND;
      result.matched_pattern = best_pattern_next;
      result.match_offset    = best_start_next;
    end
  end

  // hold the pipe only when a section result cannot leave
  assign adv = !(s2_valid && s2_last) || !out_valid || !out_stall;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pair <= pair;
      s1_last <= head.last;
      s2_cand <= merge_cand(s1_pair[0], s1_pair[1]);
      s2_last <= s1_last;
    end
    if (adv && s2_valid && s2_last) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      out_valid         <= 1'b0;
      match_seen        <= 1'b0;
      second_start_seen <= 1'b0;
      best_start        <= '0;
      best_pattern      <= '0;
    end else begin
      if (adv && s2_valid && s2_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        s1_valid <= head_valid;
        s2_valid <= s1_valid;
        if (s2_valid && s2_last) begin
          match_seen        <= 1'b0;
          second_start_seen <= 1'b0;
          best_start        <= '0;
          best_pattern      <= '0;
        end else begin
          match_seen        <= match_seen_next;
          second_start_seen <= second_start_seen_next;
          best_start        <= best_start_next;
          best_pattern      <= best_pattern_next;
        end
      end
    end
  end

endmodule

[bench/tb.sv]
module tb;
  import msps_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int PHASE_ITEMS   = 120;
  localparam int MAX_SECTION   = 100;
  localparam int STORE_DEPTH   = NUM_PATTERNS * MAX_PATTERN_LEN;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_multi_pattern_search_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Register copy, written only while the block is idle
  logic [2:0]       active_cfg = 3'd1;
  logic             unique_cfg = 1'b0;
  logic [LEN_W-1:0] len_cfg [NUM_PATTERNS] = '{default: 7'd1};

  // Scanner state as the block should hold it
  logic [7:0]  sig_byte [STORE_DEPTH];
  logic        sig_wild [STORE_DEPTH];
  logic [63:0] partial_vec [NUM_PATTERNS] = '{default: '0};
  logic [31:0] scan_pos = '0;
  logic [31:0] first_start = '0;
  logic [1:0]  first_pattern = '0;
  logic        hit_seen = 1'b0;
  logic        multi_start = 1'b0;

  // Pattern contents as the stimulus has queued them
  logic [7:0] gen_byte [STORE_DEPTH];
  logic       gen_wild [STORE_DEPTH];
  bit         loaded [STORE_DEPTH] = '{default: 1'b0};

  in_item_t  pending_items [$];
  out_item_t expected_reports [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_on = 1'b0;
  int held_cycles = 0;
  int items_sent = 0;
  int reports_checked = 0;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  int phase = 0;
  int phase_start;
  out_item_t got_report;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_count();
    return (active_cfg > NUM_PATTERNS) ? NUM_PATTERNS : int'(active_cfg);
  endfunction

  function automatic int eff_len(int p);
    return (len_cfg[p] > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len_cfg[p]);
  endfunction

  task automatic record_hit(input logic [1:0] p, input logic [31:0] start);
    if (!hit_seen) begin
      hit_seen = 1'b1;
      first_start = start;
      first_pattern = p;
    end else if (start < first_start) begin
      multi_start = 1'b1;
      first_start = start;
      first_pattern = p;
    end else if (start == first_start) begin
      if (p < first_pattern) first_pattern = p;
    end else begin
      multi_start = 1'b1;
    end
  endtask

  task automatic scan_item(input in_item_t it);
    int n;
    int len;
    logic [63:0] hits;
    logic [63:0] v;
    logic [31:0] pos;
    out_item_t rep;
    if (it.command == CMD_PATTERN_WRITE) begin
      sig_byte[{it.pattern_select, it.pattern_position}] = it.byte_value;
      sig_wild[{it.pattern_select, it.pattern_position}] = it.is_wildcard;
    end else begin
      n = eff_count();
      pos = scan_pos;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (p >= n) begin
          partial_vec[p] = '0;
        end else begin
          len = eff_len(p);
          if (len == 0) begin
            // empty pattern matches at every offset
            partial_vec[p] = '0;
            record_hit(p[1:0], pos);
          end else begin
            hits = '0;
            for (int j = 0; j < len; j++)
              if (sig_wild[p * MAX_PATTERN_LEN + j] ||
                  sig_byte[p * MAX_PATTERN_LEN + j] == it.byte_value)
                hits[j] = 1'b1;
            v = ((partial_vec[p] << 1) | 64'd1) & hits;
            partial_vec[p] = v;
            if (v[len-1]) record_hit(p[1:0], pos + 32'd1 - 32'(len));
          end
        end
      end
      scan_pos = pos + 32'd1;
      if (it.section_end) begin
        rep = '0;
        if (!hit_seen) begin
          rep.search_status = STATUS_NOT_FOUND;
        end else if (unique_cfg && multi_start) begin
          rep.search_status = STATUS_DUPLICATE;
        end else begin
          rep.search_status = STATUS_FOUND;
          rep.matched_pattern = first_pattern;
          rep.match_offset = first_start;
        end
        expected_reports.push_back(rep);
        partial_vec = '{default: '0};
        scan_pos = '0;
        first_start = '0;
        first_pattern = '0;
        hit_seen = 1'b0;
        multi_start = 1'b0;
      end
    end
  endtask

  // Sender: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_item(in_item);
        void'(pending_items.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off in the pressure phase, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (pressure_on && held_cycles < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result with no report expected: status %0d pattern %0d offset %0d",
               out_item.search_status, out_item.matched_pattern, out_item.match_offset);
        mismatch_count = mismatch_count + 1;
      end else begin
        got_report = expected_reports.pop_front();
        reports_checked <= reports_checked + 1;
        if (out_item.search_status !== got_report.search_status) begin
          $error("search_status: expected %0d, got %0d",
                 got_report.search_status, out_item.search_status);
          mismatch_count = mismatch_count + 1;
        end
        if (out_item.matched_pattern !== got_report.matched_pattern) begin
          $error("matched_pattern: expected %0d, got %0d",
                 got_report.matched_pattern, out_item.matched_pattern);
          mismatch_count = mismatch_count + 1;
        end
        if (out_item.match_offset !== got_report.match_offset) begin
          $error("match_offset: expected %0d, got %0d",
                 got_report.match_offset, out_item.match_offset);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PATTERNS_IN_USE: active_cfg = val[2:0];
      REG_REQUIRE_UNIQUE:  unique_cfg = val[0];
      REG_LENGTH_ZERO:     len_cfg[0] = val;
      REG_LENGTH_ONE:      len_cfg[1] = val;
      REG_LENGTH_TWO:      len_cfg[2] = val;
      REG_LENGTH_THREE:    len_cfg[3] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0, 1: return 8'h00;
      2, 3: return 8'hff;
      4:    return 8'h5a;
      5:    return 8'ha5;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pattern(input int p, input int j, input logic [7:0] b, input logic w);
    in_item_t it;
    it = '0;
    it.command = CMD_PATTERN_WRITE;
    it.pattern_select = p[1:0];
    it.pattern_position = j[IDX_W-1:0];
    it.byte_value = b;
    it.is_wildcard = w;
    it.section_end = 1'($urandom);
    pending_items.push_back(it);
    gen_byte[p * MAX_PATTERN_LEN + j] = b;
    gen_wild[p * MAX_PATTERN_LEN + j] = w;
    loaded[p * MAX_PATTERN_LEN + j] = 1'b1;
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it = '0;
    it.command = CMD_SECTION_BYTE;
    it.pattern_select = 2'($urandom);
    it.pattern_position = IDX_W'($urandom);
    it.byte_value = b;
    it.is_wildcard = 1'($urandom);
    it.section_end = last;
    pending_items.push_back(it);
    items_sent++;
  endtask

  // Load every pattern entry the current settings will read that is not yet loaded
  task automatic fill_missing();
    for (int p = 0; p < eff_count(); p++)
      for (int j = 0; j < eff_len(p); j++)
        if (!loaded[p * MAX_PATTERN_LEN + j])
          send_pattern(p, j, pick_byte(), $urandom_range(3) == 0);
  endtask

  task automatic send_section();
    logic [7:0] sec [MAX_SECTION];
    int n_act;
    int slen;
    int p;
    int plen;
    int at;
    int copies;
    n_act = eff_count();
    slen = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 16);
    if (n_act > 0 && $urandom_range(3) != 0) begin
      p = $urandom_range(n_act - 1);
      plen = eff_len(p);
      if (plen > slen) slen = plen + $urandom_range(8);
    end
    for (int i = 0; i < slen; i++) sec[i] = pick_byte();
    copies = (n_act > 0) ? $urandom_range(2) : 0;
    for (int c = 0; c < copies; c++) begin
      p = $urandom_range(n_act - 1);
      plen = eff_len(p);
      if (plen > 0 && plen <= slen) begin
        at = $urandom_range(slen - plen);
        for (int j = 0; j < plen; j++)
          sec[at + j] = gen_wild[p * MAX_PATTERN_LEN + j] ? pick_byte()
                                                            : gen_byte[p * MAX_PATTERN_LEN + j];
      end
    end
    for (int i = 0; i < slen; i++) begin
      // rewrite a pattern entry in the middle of the section now and then
      if ($urandom_range(24) == 0)
        send_pattern($urandom_range(NUM_PATTERNS - 1), $urandom_range(MAX_PATTERN_LEN - 1),
                     pick_byte(), $urandom_range(3) == 0);
      send_byte(sec[i], i == slen - 1);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_length();
    case ($urandom_range(19))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'($urandom_range(65, 127));
      3, 4:    return 7'($urandom_range(9, 40));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one pattern of length one, as after reset
    @(negedge clk);
    send_pattern(0, 0, 8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // two patterns matching at one start, then a duplicate, then a too-short section
    write_reg(REG_PATTERNS_IN_USE, 7'd2);
    write_reg(REG_REQUIRE_UNIQUE, 7'd1);
    write_reg(REG_LENGTH_ZERO, 7'd2);
    write_reg(REG_LENGTH_ONE, 7'd2);
    @(negedge clk);
    send_pattern(0, 0, 8'hab, 1'b0);
    send_pattern(0, 1, 8'hff, 1'b1);
    send_pattern(1, 0, 8'hab, 1'b0);
    send_pattern(1, 1, 8'hcd, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b1);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hab, 1'b1);
    wait_idle();

    // no pattern in use
    write_reg(REG_PATTERNS_IN_USE, 7'd0);
    @(negedge clk);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b1);
    wait_idle();

    // count above range, empty pattern, over-long pattern
    write_reg(REG_PATTERNS_IN_USE, 7'd7);
    write_reg(REG_REQUIRE_UNIQUE, 7'd0);
    write_reg(REG_LENGTH_TWO, 7'd0);
    write_reg(REG_LENGTH_THREE, 7'd127);
    @(negedge clk);
    send_pattern(3, 63, 8'hff, 1'b1);
    fill_missing();
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b1);
    wait_idle();

    phase_start = items_sent;
    while (items_sent - phase_start < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (phase == 0) begin
        write_reg(REG_PATTERNS_IN_USE, 7'd4);
        write_reg(REG_REQUIRE_UNIQUE, 7'd1);
        for (int p = 0; p < NUM_PATTERNS; p++)
          write_reg(cfg_reg_e'(REG_LENGTH_ZERO + p), 7'd64);
      end else if (phase == 1) begin
        write_reg(REG_PATTERNS_IN_USE, 7'd4);
        write_reg(REG_REQUIRE_UNIQUE, 7'd0);
        for (int p = 0; p < NUM_PATTERNS; p++)
          write_reg(cfg_reg_e'(REG_LENGTH_ZERO + p), 7'd1);
      end else begin
        case ($urandom_range(9))
          0:       write_reg(REG_PATTERNS_IN_USE, 7'd0);
          1:       write_reg(REG_PATTERNS_IN_USE, 7'($urandom_range(5, 7)));
          default: write_reg(REG_PATTERNS_IN_USE, 7'($urandom_range(1, 4)));
        endcase
        write_reg(REG_REQUIRE_UNIQUE, 7'($urandom_range(1)));
        for (int p = 0; p < NUM_PATTERNS; p++)
          write_reg(cfg_reg_e'(REG_LENGTH_ZERO + p), random_length());
      end
      pressure_on = (phase == 4);
      @(negedge clk);
      fill_missing();
      begin
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < PHASE_ITEMS) send_section();
      end
      wait_idle();
      pressure_on = 1'b0;
      phase++;
    end

    $display("%0d items driven over %0d random setting phases after the directed sections",
             items_sent, phase);
    $display("%0d section reports checked, %0d mismatches", reports_checked, mismatch_count);
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
